// ===== src/integer_to_ascii_digits_macros.svh =====
// Assertion macros for the integer to ASCII digit converter
`ifndef INTEGER_TO_ASCII_DIGITS_MACROS_SVH
`define INTEGER_TO_ASCII_DIGITS_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define ITOA_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ITOA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/itoa_pkg.sv =====
// Types and constants for the integer to ASCII digit converter
`default_nettype none

package itoa_pkg;

  localparam int NUM_DIGITS = 20;  // enough for 2**64 - 1 in decimal
  localparam int DIGIT_W    = 4;
  localparam int DCNT_W     = 5;   // holds NUM_DIGITS
  localparam int BCNT_W     = 6;   // indexes 64 value bits
  localparam int VALUE_W    = 64;
  localparam int OCT_W      = 32;
  localparam int CHAR_W     = 6;

  localparam logic [1:0] ASCII_DIGIT_HI = 2'b11;  // '0'..'9' are 6'b11_xxxx
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SKIP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_t;

endpackage

`default_nettype wire

// ===== src/integer_to_ascii_digits.sv =====
// The value is converted in ST_CONV over 64 (decimal) or 32 (octal) bits; then
// ST_SKIP drops the suppressed leading zero digits (at most 19) before the first
// character. Characters go out one per cycle while out_ready is high; the next
// item is taken once the last character has gone. The bit-serial shift loop,
// with add-3 for decimal digits, sets the conversion time.
// Synchronous active-high reset returns the block to idle with no beat pending.
`default_nettype none

module integer_to_ascii_digits (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        func,
  input  wire logic [63:0] value,
  input  wire logic        leading_zero,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [5:0]       digit_char,
  output logic             last
);

  import itoa_pkg::*;
  `include "integer_to_ascii_digits_macros.svh"

  state_t              state, state_next;
  logic [VALUE_W-1:0]  value_sr;
  logic                octal;
  logic                prefix;
  logic [BCNT_W-1:0]   bit_cnt;
  logic [DCNT_W-1:0]   dig_cnt;
  digits_t             digits, digits_shift;
  logic [NUM_DIGITS-1:0] carry;
  logic                in_beat, out_beat;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_EMIT);
  assign in_beat   = in_valid && in_ready;
  assign out_beat  = out_valid && out_ready;

  assign digit_char = prefix ? ASCII_ZERO : {ASCII_DIGIT_HI, digits[NUM_DIGITS-1]};
  assign last       = !prefix && (dig_cnt == DCNT_W'(1));

  // One value bit enters digit 0 per cycle; each digit passes its top bit on.
  // Decimal digits get the add-3 correction first, octal digits use 3 bits.
  always_comb begin
    logic [DIGIT_W-1:0] d;
    logic               cin;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      d   = digits[i];
      cin = (i == 0) ? value_sr[VALUE_W-1] : carry[(i == 0) ? 0 : i-1];
      if (octal) begin
        carry[i]        = d[2];
        digits_shift[i] = {1'b0, d[1:0], cin};
      end else begin
        if (d >= DIGIT_W'(5)) begin
          d = d + DIGIT_W'(3);
        end
        carry[i]        = d[3];
        digits_shift[i] = {d[2:0], cin};
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_beat) begin
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        if (bit_cnt == '0) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (digits[NUM_DIGITS-1] != '0 || dig_cnt == DCNT_W'(1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_beat && last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_beat) begin
          octal   <= func;
          prefix  <= func && leading_zero && (value[OCT_W-1:0] != '0);
          digits  <= '0;
          dig_cnt <= DCNT_W'(NUM_DIGITS);
          if (func) begin
            value_sr <= {value[OCT_W-1:0], {(VALUE_W-OCT_W){1'b0}}};
            bit_cnt  <= BCNT_W'(OCT_W - 1);
          end else begin
            value_sr <= value;
            bit_cnt  <= BCNT_W'(VALUE_W - 1);
          end
        end
      end
      ST_CONV: begin
        digits   <= digits_shift;
        value_sr <= {value_sr[VALUE_W-2:0], 1'b0};
        bit_cnt  <= bit_cnt - BCNT_W'(1);
      end
      ST_SKIP: begin
        if (digits[NUM_DIGITS-1] == '0 && dig_cnt != DCNT_W'(1)) begin
          digits  <= {digits[NUM_DIGITS-2:0], {DIGIT_W{1'b0}}};
          dig_cnt <= dig_cnt - DCNT_W'(1);
        end
      end
      ST_EMIT: begin
        if (out_beat) begin
          if (prefix) begin
            prefix <= 1'b0;
          end else if (!last) begin
            digits  <= {digits[NUM_DIGITS-2:0], {DIGIT_W{1'b0}}};
            dig_cnt <= dig_cnt - DCNT_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  `ITOA_ASSERT_NOW(a_no_overlap, in_ready, !out_valid, "input taken while a beat is pending")
  `ITOA_ASSERT_NEXT(a_last_frees, out_beat && last, in_ready, "not idle after final beat")
  `ITOA_ASSERT_NOW(a_digit_range, out_valid, digit_char <= 6'd57, "character is not a digit")
  `ITOA_ASSERT_NOW(a_prefix_not_last, out_valid && prefix, !last, "prefix marked last")

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Testbench for the integer to ASCII digit converter: directed table, then random numbers
`timescale 1ns / 100ps

module tb;
  import itoa_pkg::*;

  localparam int N_DIRECTED = 21;
  localparam int N_RANDOM   = 80;
  localparam int IDLE_LIMIT = 3000;  // cycles with no beat on either side
  localparam int DRAIN_WAIT = 120;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              fin;
  } char_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        func = 1'b0;
  logic [63:0] value = '0;
  logic        leading_zero = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  digit_char;
  logic        last;

  char_beat_t chars_due [$];
  int  fault_count = 0;
  int  numbers_sent = 0;
  int  chars_seen = 0;
  int  idle_cycles = 0;
  int  stall_left = 0;
  bit  calm = 1'b0;  // no gaps on either side while set

  // directed table; empty text means the predictor supplies the digits
  logic        dir_func [0:N_DIRECTED-1] = '{
    1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
  logic [63:0] dir_value [0:N_DIRECTED-1] = '{
    64'd0, 64'd0, 64'd0, 64'd0,
    64'd18446744073709551615, 64'd18446744073709551615,
    64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000,
    64'd9, 64'd10, 64'd10000000000000000000, 64'd9999999999999999999,
    64'd7, 64'd8, 64'd1, 64'd1,
    64'h1234_5678_9ABC_DEF0, 64'h8000_0000_0000_0000, 64'h0000_0000_8000_0000,
    64'h0123_4567_89AB_CDEF};
  logic        dir_lz [0:N_DIRECTED-1] = '{
    1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1,
    1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
  string       dir_text [0:N_DIRECTED-1] = '{
    "0", "0", "0", "0",
    "18446744073709551615", "18446744073709551615",
    "37777777777", "037777777777", "0",
    "9", "10", "10000000000000000000", "9999999999999999999",
    "07", "10", "01", "1",
    "", "", "020000000000", ""};

  integer_to_ascii_digits DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .value        (value),
    .leading_zero (leading_zero),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .digit_char   (digit_char),
    .last         (last)
  );

  always #5 clk = ~clk;

  // digits of one number, most significant first, onto the expected queue
  function automatic void predict_digits(input logic oct, input logic [63:0] v,
                                         input logic lz);
    logic [CHAR_W-1:0] rev [$];
    logic [63:0]       dec_rest;
    logic [31:0]       oct_rest;
    char_beat_t        b;
    if (oct) begin
      oct_rest = v[31:0];
      do begin
        rev.push_back(ASCII_ZERO + CHAR_W'(oct_rest % 32'd8));
        oct_rest = oct_rest / 32'd8;
      end while (oct_rest != 0);
      if (lz && v[31:0] != 0) rev.push_back(ASCII_ZERO);
    end else begin
      dec_rest = v;
      do begin
        rev.push_back(ASCII_ZERO + CHAR_W'(dec_rest % 64'd10));
        dec_rest = dec_rest / 64'd10;
      end while (dec_rest != 0);
    end
    for (int k = rev.size() - 1; k >= 0; k--) begin
      b.ch  = rev[k];
      b.fin = (k == 0);
      chars_due.push_back(b);
    end
  endfunction

  function automatic void expect_text(input string s);
    logic [7:0] c;
    char_beat_t b;
    for (int i = 0; i < s.len(); i++) begin
      c     = s[i];
      b.ch  = c[CHAR_W-1:0];
      b.fin = (i == s.len() - 1);
      chars_due.push_back(b);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // one number on the input channel; expectation queued at the accepting edge
  task automatic send_number(input logic oct, input logic [63:0] v, input logic lz,
                             input string text);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    func         <= oct;
    value        <= v;
    leading_zero <= lz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (text.len() != 0) expect_text(text);
    else predict_digits(oct, v, lz);
    numbers_sent++;
  endtask

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0, 1: ;
      2: v = v >> $urandom_range(1, 63);
      3: v = 64'($urandom_range(0, 20));
      default: begin
        // digit-count boundaries: powers of ten or eight, sometimes minus one
        v = 64'd1;
        if ($urandom_range(0, 1)) repeat ($urandom_range(0, 19)) v = v * 64'd10;
        else v = v << (3 * $urandom_range(0, 10));
        if ($urandom_range(0, 1)) v = v - 64'd1;
        v[63:32] = v[63:32] | ($urandom_range(0, 3) == 0 ? $urandom : 32'd0);
      end
    endcase
    return v;
  endfunction

  // output side: stalls, checking, watchdog
  always @(posedge clk) begin
    char_beat_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        chars_seen++;
        if (chars_due.size() == 0) begin
          $error("unexpected beat: digit_char %0d last %0b", digit_char, last);
          fault_count++;
        end else begin
          want = chars_due.pop_front();
          if (digit_char !== want.ch) begin
            $error("digit_char: expected %0d, got %0d", want.ch, digit_char);
            fault_count++;
          end
          if (last !== want.fin) begin
            $error("last: expected %0b, got %0b", want.fin, last);
            fault_count++;
          end
        end
      end

      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: timeout after %0d quiet cycles", idle_cycles);
        $display("tb: errors");
        $finish;
      end

      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                 : $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++)
      send_number(dir_func[i], dir_value[i], dir_lz[i], dir_text[i]);

    for (int i = 0; i < N_RANDOM; i++) begin
      calm = (i >= 40 && i < 55);
      send_number(1'($urandom_range(0, 1)), random_value(), 1'($urandom_range(0, 1)), "");
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (chars_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("tb: %0d numbers in both radices, %0d characters checked",
             numbers_sent, chars_seen);
    if (fault_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
